[sv/tlmd_pkg.sv]
// ----------------------------------------------------------------------------
// tlmd_pkg
// shared types and constants for the type-length message deframer
// ----------------------------------------------------------------------------
package tlmd_pkg;

  localparam int unsigned HDR_BYTES = 5;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned LIMIT_W   = 9;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned DATA_W    = 32;

  localparam logic [1:0] ST_BODY     = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_ZERO_LEN = 2'd2;

  localparam logic [CNT_W-1:0] HDR_CNT_TYPE = CNT_W'(0);
  localparam logic [CNT_W-1:0] HDR_CNT_DONE = CNT_W'(HDR_BYTES);

  localparam logic [LIMIT_W-1:0] TYPE_LIMIT_RST = LIMIT_W'(256);

  localparam logic REG_TYPE_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       msg_type;
    logic [LEN_W-1:0] message_length;
    logic [7:0]       payload_byte;
    logic             last_byte;
  } tlmd_result_t;

endpackage

[sv/tlmd_cfg.sv]
// ----------------------------------------------------------------------------
// tlmd_cfg
// apb-style register slave holding the type limit
// ----------------------------------------------------------------------------
module tlmd_cfg import tlmd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [ADDR_W-1:0]  cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready,
  output logic [LIMIT_W-1:0] type_limit
);

  logic [LIMIT_W-1:0] type_limit_r;
  logic [LIMIT_W-1:0] type_limit_nxt;
  logic               reg_sel;

  assign reg_sel    = (cfg_paddr[ADDR_W-1] == REG_TYPE_LIMIT);
  assign cfg_pready = 1'b1;

  always_comb begin
    type_limit_nxt = type_limit_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && reg_sel) begin
      type_limit_nxt = cfg_pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_limit_r <= TYPE_LIMIT_RST;
    end else begin
      type_limit_r <= type_limit_nxt;
    end
  end

  assign cfg_prdata = reg_sel ? DATA_W'(type_limit_r) : '0;
  assign type_limit = type_limit_r;

endmodule

[sv/tlmd_parser.sv]
// ----------------------------------------------------------------------------
// tlmd_parser
// header collection, header checks and body byte tagging
// ----------------------------------------------------------------------------
module tlmd_parser import tlmd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         data_byte,
  input  logic [LIMIT_W-1:0] type_limit,
  output logic               res_valid,
  output tlmd_result_t       res
);

  logic [CNT_W-1:0] header_count_r, header_count_nxt;
  logic [7:0]       held_type_r, held_type_nxt;
  logic [LEN_W-1:0] held_length_r, held_length_nxt;
  logic [LEN_W-1:0] body_count_r, body_count_nxt;
  logic [CNT_W-1:0] hdr_inc;
  logic [LEN_W-1:0] body_inc;
  logic             bad_type;
  logic             is_last;

  assign hdr_inc  = header_count_r + CNT_W'(1);
  assign body_inc = body_count_r + LEN_W'(1);
  assign is_last  = (body_inc == held_length_r);
  assign bad_type = (held_type_r == 8'd0) || ({1'b0, held_type_r} >= type_limit);

  always_comb begin
    header_count_nxt   = header_count_r;
    held_type_nxt      = held_type_r;
    held_length_nxt    = held_length_r;
    body_count_nxt     = body_count_r;
    res_valid          = 1'b0;
    res.status         = ST_BODY;
    res.payload_byte   = 8'd0;
    res.last_byte      = 1'b0;
    if (header_count_r < HDR_CNT_DONE) begin
      if (header_count_r == HDR_CNT_TYPE) begin
        held_type_nxt   = data_byte;
        held_length_nxt = '0;
      end else begin
        held_length_nxt = {held_length_r[LEN_W-9:0], data_byte};
      end
      header_count_nxt = hdr_inc;
      body_count_nxt   = '0;
      if (hdr_inc == HDR_CNT_DONE) begin
        if (bad_type) begin
          header_count_nxt = HDR_CNT_TYPE;
          res_valid        = accept;
          res.status       = ST_BAD_TYPE;
        end else if (held_length_nxt == '0) begin
          header_count_nxt = HDR_CNT_TYPE;
          res_valid        = accept;
          res.status       = ST_ZERO_LEN;
        end
      end
    end else begin
      body_count_nxt   = body_inc;
      res_valid        = accept;
      res.payload_byte = data_byte;
      res.last_byte    = is_last;
      if (is_last) begin
        header_count_nxt = HDR_CNT_TYPE;
        body_count_nxt   = '0;
      end
    end
    res.msg_type       = held_type_nxt;
    res.message_length = held_length_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r <= HDR_CNT_TYPE;
      held_type_r    <= '0;
      held_length_r  <= '0;
      body_count_r   <= '0;
    end else if (accept) begin
      header_count_r <= header_count_nxt;
      held_type_r    <= held_type_nxt;
      held_length_r  <= held_length_nxt;
      body_count_r   <= body_count_nxt;
    end
  end

endmodule

[sv/tlmd_out_buf.sv]
// ----------------------------------------------------------------------------
// tlmd_out_buf
// result register with a skid entry so input keeps flowing under stall
// ----------------------------------------------------------------------------
module tlmd_out_buf import tlmd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  tlmd_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output tlmd_result_t out_data
);

  logic         out_valid_r, out_valid_nxt;
  logic         skid_valid_r, skid_valid_nxt;
  tlmd_result_t out_data_r, out_data_nxt;
  tlmd_result_t skid_data_r, skid_data_nxt;
  logic         take;

  assign take = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || take) begin
      out_valid_nxt = push;
      out_data_nxt  = push_data;
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[sv/type_length_message_deframer.sv]
// ----------------------------------------------------------------------------
// type_length_message_deframer
// splits a byte stream into type, 32-bit big-endian length and body bytes
// ----------------------------------------------------------------------------
// one byte is taken per cycle while in_stall is low, and results are given
// from the result register; header bytes give no result except an error on
// the fifth, body bytes give one each. a two-entry result buffer (result
// register plus skid entry) sets the rate under stall: in_stall rises only
// when both entries hold untaken results. the type limit register sits at
// byte address 0 of the apb-style port and resets to 256.
module type_length_message_deframer import tlmd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [7:0]        out_msg_type,
  output logic [LEN_W-1:0]  out_message_length,
  output logic [7:0]        out_payload_byte,
  output logic              out_last_byte,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic               accept;
  logic               res_valid;
  logic               buf_full;
  logic [LIMIT_W-1:0] type_limit;
  tlmd_result_t       res;
  tlmd_result_t       out_data;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  tlmd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .type_limit  (type_limit)
  );

  tlmd_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .type_limit (type_limit),
    .res_valid  (res_valid),
    .res        (res)
  );

  tlmd_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_status         = out_data.status;
  assign out_msg_type       = out_data.msg_type;
  assign out_message_length = out_data.message_length;
  assign out_payload_byte   = out_data.payload_byte;
  assign out_last_byte      = out_data.last_byte;

endmodule

[dv/type_length_message_deframer_tb.sv]
// ----------------------------------------------------------------------------
// type_length_message_deframer_tb
// self-checking bench: random framed byte streams against a built-in predictor
// ----------------------------------------------------------------------------
// messages are sent one byte per transfer: a type byte, a big-endian length
// and the body. a predictor tracks the header count, type, length and body
// count and works out the result for every accepted byte. results are
// compared field by field in order of arrival. the type limit is rewritten
// between phases while the block is idle, including zero, one, 255, 256, 511
// and values with bits above the register width. the input idles and the
// result side stalls at random.
// ----------------------------------------------------------------------------
module type_length_message_deframer_tb;
  import tlmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  class deframer_checker;
    logic [LIMIT_W-1:0] type_limit;
    logic [CNT_W-1:0]   hdr_cnt;
    logic [7:0]         cur_type;
    logic [LEN_W-1:0]   cur_len;
    logic [LEN_W-1:0]   body_cnt;
    tlmd_result_t       due_results[$];
    int                 errors;

    function new();
      type_limit = TYPE_LIMIT_RST;
      hdr_cnt    = HDR_CNT_TYPE;
      cur_type   = '0;
      cur_len    = '0;
      body_cnt   = '0;
      errors     = 0;
    endfunction

    function void set_limit(logic [DATA_W-1:0] value);
      type_limit = value[LIMIT_W-1:0];
    endfunction

    function tlmd_result_t make_result(logic [1:0] st, logic [7:0] pay, logic last);
      tlmd_result_t r;
      r.status         = st;
      r.msg_type       = cur_type;
      r.message_length = cur_len;
      r.payload_byte   = pay;
      r.last_byte      = last;
      return r;
    endfunction

    function void take_byte(logic [7:0] b);
      logic last;
      if (hdr_cnt < HDR_CNT_DONE) begin
        if (hdr_cnt == HDR_CNT_TYPE) begin
          cur_type = b;
          cur_len  = '0;
        end else begin
          cur_len = {cur_len[LEN_W-9:0], b};
        end
        hdr_cnt  = hdr_cnt + 1'b1;
        body_cnt = '0;
        if (hdr_cnt == HDR_CNT_DONE) begin
          if (cur_type == 8'd0 || {1'b0, cur_type} >= type_limit) begin
            due_results.push_back(make_result(ST_BAD_TYPE, 8'd0, 1'b0));
            hdr_cnt = HDR_CNT_TYPE;
          end else if (cur_len == '0) begin
            due_results.push_back(make_result(ST_ZERO_LEN, 8'd0, 1'b0));
            hdr_cnt = HDR_CNT_TYPE;
          end
        end
      end else begin
        body_cnt = body_cnt + 1'b1;
        last = (body_cnt == cur_len);
        due_results.push_back(make_result(ST_BODY, b, last));
        if (last) begin
          hdr_cnt  = HDR_CNT_TYPE;
          body_cnt = '0;
        end
      end
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task match_result(tlmd_result_t got);
      tlmd_result_t exp;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing due: %p", got));
      end else begin
        exp = due_results.pop_front();
        if (got.status !== exp.status)
          report($sformatf("status %0d, predicted %0d", got.status, exp.status));
        if (got.msg_type !== exp.msg_type)
          report($sformatf("msg_type %0h, predicted %0h", got.msg_type, exp.msg_type));
        if (got.message_length !== exp.message_length)
          report($sformatf("message_length %0h, predicted %0h",
                           got.message_length, exp.message_length));
        if (got.payload_byte !== exp.payload_byte)
          report($sformatf("payload_byte %0h, predicted %0h",
                           got.payload_byte, exp.payload_byte));
        if (got.last_byte !== exp.last_byte)
          report($sformatf("last_byte %0b, predicted %0b", got.last_byte, exp.last_byte));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        in_data_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        out_status;
  logic [7:0]        out_msg_type;
  logic [LEN_W-1:0]  out_message_length;
  logic [7:0]        out_payload_byte;
  logic              out_last_byte;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0] cfg_pwdata = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  deframer_checker    sb = new();
  logic [LIMIT_W-1:0] cur_limit = TYPE_LIMIT_RST;
  logic               no_gaps = 1'b0;
  int unsigned        bytes_sent = 0;
  int unsigned        stall_run = 0;
  int unsigned        free_run = 0;

  type_length_message_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_msg_type       (out_msg_type),
    .out_message_length (out_message_length),
    .out_payload_byte   (out_payload_byte),
    .out_last_byte      (out_last_byte),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always #10 clk = ~clk;

  // result side stall pattern: short bursts, a few long ones, quiet stretches
  always @(posedge clk) begin
    if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else if (free_run != 0) begin
      out_stall <= 1'b0;
      free_run--;
    end else begin
      out_stall <= 1'b0;
      free_run  = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 6);
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.match_result({out_status, out_msg_type, out_message_length,
                       out_payload_byte, out_last_byte});
  end

  task send_byte(logic [7:0] b);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 40);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.take_byte(b);
    bytes_sent++;
  endtask

  task send_message(logic [7:0] t, logic [LEN_W-1:0] len);
    send_byte(t);
    for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (t != 8'd0 && {1'b0, t} < cur_limit && len != '0)
      for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
  endtask

  task wait_idle();
    in_valid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_limit(logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(4 * REG_TYPE_LIMIT);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_limit(value);
    cur_limit = value[LIMIT_W-1:0];
  endtask

  task random_message();
    int unsigned      r;
    int unsigned      max_good;
    logic             has_good;
    logic [7:0]       t;
    logic [LEN_W-1:0] len;
    r        = $urandom_range(0, 99);
    has_good = (cur_limit > 1);
    max_good = (cur_limit > 255) ? 255 : cur_limit - 1;
    r = (r < 70) ? $urandom_range(0, 99) : 100 + r;
    if (has_good && r < 100) begin
      t = 8'($urandom_range(1, max_good));
      r = $urandom_range(0, 99);
      if (r < 80) len = $urandom_range(1, 8);
      else if (r < 97) len = $urandom_range(9, 48);
      else len = $urandom_range(256, 300);
    end else if (r < 182 || !has_good) begin
      if (cur_limit > 255 || $urandom_range(0, 3) == 0) t = 8'd0;
      else t = 8'($urandom_range(cur_limit, 255));
      len = ($urandom_range(0, 4) == 0) ? '0 : $urandom;
    end else if (r < 192) begin
      t   = 8'($urandom_range(1, max_good));
      len = '0;
    end else begin
      t = 8'($urandom_range(0, 255));
      if (t != 8'd0 && {1'b0, t} < cur_limit) len = $urandom_range(0, 15);
      else len = $urandom;
    end
    send_message(t, len);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] limits[10];
    int unsigned       phase_start;
    limits = '{32'd0, 32'd1, 32'd2, 32'd255, 32'hFFFF_FFFF,
               32'd256, 32'd128, 32'd0, 32'd300, 32'h0000_FE40};
    limits[7] = $urandom_range(3, 254);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: widest type, both header errors, type check ahead of length
    send_message(8'hFF, 32'd1);
    send_message(8'h00, 32'd0);
    send_message(8'h01, 32'd0);
    send_message(8'h00, 32'hFFFF_FFFF);
    repeat (15) random_message();

    for (int p = 0; p < 10; p++) begin
      wait_idle();
      write_limit(limits[p]);
      no_gaps = (p % 3 == 1);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 60) begin
        random_message();
        if (p == 5 && bytes_sent - phase_start >= 30 && bytes_sent - phase_start < 45)
          wait_idle();
      end
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (sb.due_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.due_results.size()));
    if (sb.errors == 0) begin
      $display("PASS type_length_message_deframer");
    end else begin
      $display("FAIL type_length_message_deframer");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL type_length_message_deframer");
    $finish;
  end

endmodule
